@@ sv/sre_pkg.sv @@
package sre_pkg;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_RUN0,
      S_RUN1,
      S_RUN2,
      S_FLUSH,
      S_ESC0,
      S_ESC1,
      S_ESC2,
      S_LIT
   } state_type;

   typedef enum logic [1:0] {
      MID_NONE,
      MID_LIT,
      MID_ESC
   } mid_type;

   typedef struct packed {
      logic write;
      logic shift;
   } pend_ctrl_type;

   localparam logic [1:0] CSR_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_LEVEL     = 2'd1;
   localparam logic [1:0] CSR_BAND      = 2'd2;
   localparam logic [1:0] CSR_THRESHOLD = 2'd3;

   localparam logic [7:0] ESC_BYTE = 8'd0;
   localparam logic [7:0] ESC_TAIL = 8'd1;
   localparam logic [8:0] RUN_CAP  = 9'd255;

endpackage

@@ sv/sre_cell.sv @@
module sre_cell (
   input  logic       clock,
   input  logic       load,
   input  logic       shift,
   input  logic [7:0] load_data,
   input  logic [7:0] neighbor_data,
   output logic [7:0] value
);

   logic [7:0] value_ff;
   logic [7:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (load) begin
         value_in = load_data;
      end else if (shift) begin
         value_in = neighbor_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ sv/sre_pend_chain.sv @@
module sre_pend_chain #(
   parameter int PENDING_DEPTH = 15,
   localparam int IDX_W = $clog2(PENDING_DEPTH + 1)
) (
   input  logic                  clock,
   input  sre_pkg::pend_ctrl_type ctrl,
   input  logic [IDX_W-1:0]      wr_index,
   input  logic [7:0]            wr_data,
   output logic [7:0]            head_data
);

   import sre_pkg::*;

   logic [7:0] cell_value [PENDING_DEPTH];

   for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
      logic [7:0] neighbor;
      logic       load;

      if (i == PENDING_DEPTH - 1) begin : g_tail
         assign neighbor = '0;
      end else begin : g_body
         assign neighbor = cell_value[i + 1];
      end

      assign load = ctrl.write && (wr_index == IDX_W'(i));

      sre_cell u_cell (
         .clock         (clock),
         .load          (load),
         .shift         (ctrl.shift),
         .load_data     (wr_data),
         .neighbor_data (neighbor),
         .value         (cell_value[i])
      );
   end

   assign head_data = cell_value[0];

endmodule

@@ sv/silence_run_length_encoder_unit.sv @@
// silence run-length encoder
// req channel: one 8-bit audio sample per transaction, req_tlast marks the
// last sample of a packet. rsp channel: one encoded byte per transaction,
// rsp_tuser is set on the last byte caused by an input sample, rsp_tlast
// on the final byte of a packet. csr port: write enable, register index,
// data; it is to be written only while the block is idle, which the block
// itself does not enforce. a sample is taken in S_IDLE and evaluated in
// S_EVAL, then the sequencer produces one output byte per cycle while the
// receiver takes them; a sample causes 0 to PENDING_DEPTH + 3 bytes (18 by
// default). the single output register sets the pace: one byte leaves per
// cycle while the receiver takes it. held-back samples sit in a shift
// chain of PENDING_DEPTH cells and drain from its head one byte per cycle
// while rsp is not stalled. after S_EVAL a sample's first byte goes into
// the output register and then onto rsp. reset clears the sequencer, run
// state, pending count and output valid and loads register defaults; it
// needs no clearing pass. when the receiver stalls, the current byte holds
// in the output register and the sequencer waits; req_tready stays low
// until the last byte of the burst is in the output register.
module silence_run_length_encoder_unit #(
   parameter int PENDING_DEPTH = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // sample_in[7:0]
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // out_byte[7:0]
   output logic       rsp_tuser,  // burst_last
   output logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   import sre_pkg::*;

   localparam int          CNT_W   = $clog2(PENDING_DEPTH + 1);
   localparam logic [8:0]  THR_MAX = 9'(PENDING_DEPTH + 1);

   // configuration
   logic       enable_ff;
   logic [7:0] level_ff;
   logic [6:0] band_ff;
   logic [4:0] thr_ff;

   // item and state
   logic [7:0]       sample_ff;
   logic             last_ff;
   state_type        state_ff, state_in;
   logic             in_run_ff, in_run_in;
   logic [7:0]       streak_ff, streak_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // plan for the current item
   logic       do_run_in;
   logic [7:0] run_val_ff, run_val_in;
   logic       do_flush_ff, do_flush_in;
   mid_type    mid_ff, mid_in;
   logic       store;
   logic       in_run_n;
   logic [7:0] streak_n;
   logic [CNT_W-1:0] count_n;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_burst_ff;
   logic       rsp_end_ff;

   logic          slot_free;
   logic          emit;
   logic [7:0]    emit_byte;
   logic          burst_last;
   logic [7:0]    head_data;
   pend_ctrl_type chain_ctrl;

   logic [8:0] step;
   logic [8:0] thr_eff;
   logic       inb;
   logic       zero;

   function automatic state_type mid_state(input mid_type kind);
      state_type st;
      st = S_IDLE;
      case (kind)
         MID_LIT: st = S_LIT;
         MID_ESC: st = S_ESC0;
         default: st = S_IDLE;
      endcase
      return st;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         level_ff  <= 8'd128;
         band_ff   <= 7'd2;
         thr_ff    <= 5'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:    enable_ff <= csr_wdata[0];
            CSR_LEVEL:     level_ff  <= csr_wdata;
            CSR_BAND:      band_ff   <= csr_wdata[6:0];
            CSR_THRESHOLD: thr_ff    <= csr_wdata[4:0];
            default:       ;
         endcase
      end
   end

   // item evaluation
   always_comb begin
      step    = {1'b0, streak_ff} + 9'd1;
      thr_eff = {4'b0, thr_ff};
      if (thr_eff == 9'd0) begin
         thr_eff = 9'd1;
      end else if (thr_eff > THR_MAX) begin
         thr_eff = THR_MAX;
      end
      inb  = (({1'b0, sample_ff} + {2'b0, band_ff}) >= {1'b0, level_ff}) &&
             ({1'b0, sample_ff} <= ({1'b0, level_ff} + {2'b0, band_ff}));
      zero = (sample_ff == 8'd0);

      do_run_in   = 1'b0;
      run_val_in  = streak_ff;
      do_flush_in = 1'b0;
      mid_in      = MID_NONE;
      store       = 1'b0;
      in_run_n    = in_run_ff;
      streak_n    = streak_ff;
      count_n     = count_ff;

      if (!enable_ff) begin
         do_run_in   = in_run_ff;
         do_flush_in = !in_run_ff;
         mid_in      = MID_LIT;
         in_run_n    = 1'b0;
         streak_n    = '0;
      end else if (in_run_ff && inb) begin
         if (step >= RUN_CAP || last_ff) begin
            do_run_in  = 1'b1;
            run_val_in = step[7:0];
            in_run_n   = 1'b0;
            streak_n   = '0;
         end else begin
            streak_n = step[7:0];
         end
      end else if (in_run_ff) begin
         do_run_in = 1'b1;
         mid_in    = zero ? MID_ESC : MID_LIT;
         in_run_n  = 1'b0;
         streak_n  = '0;
      end else if (zero) begin
         do_flush_in = 1'b1;
         mid_in      = MID_ESC;
         streak_n    = '0;
      end else if (inb) begin
         if (step >= thr_eff) begin
            count_n = '0;
            if (last_ff) begin
               do_run_in  = 1'b1;
               run_val_in = step[7:0];
               streak_n   = '0;
            end else begin
               in_run_n = 1'b1;
               streak_n = step[7:0];
            end
         end else begin
            store   = 1'b1;
            count_n = count_ff + CNT_W'(1);
            if (last_ff) begin
               do_flush_in = 1'b1;
               streak_n    = '0;
            end else begin
               streak_n = step[7:0];
            end
         end
      end else begin
         do_flush_in = 1'b1;
         mid_in      = MID_LIT;
         streak_n    = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (do_run_in) begin
               state_in = S_RUN0;
            end else if (do_flush_in && count_n != '0) begin
               state_in = S_FLUSH;
            end else begin
               state_in = mid_state(mid_in);
            end
         end
         S_RUN0: if (slot_free) state_in = S_RUN1;
         S_RUN1: if (slot_free) state_in = S_RUN2;
         S_RUN2: begin
            if (slot_free) begin
               if (do_flush_ff && count_ff != '0) begin
                  state_in = S_FLUSH;
               end else begin
                  state_in = mid_state(mid_ff);
               end
            end
         end
         S_FLUSH: begin
            if (slot_free && count_ff == CNT_W'(1)) state_in = mid_state(mid_ff);
         end
         S_ESC0: if (slot_free) state_in = S_ESC1;
         S_ESC1: if (slot_free) state_in = S_ESC2;
         S_ESC2: if (slot_free) state_in = S_IDLE;
         S_LIT:  if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      emit             = 1'b0;
      emit_byte        = sample_ff;
      chain_ctrl.write = 1'b0;
      chain_ctrl.shift = 1'b0;
      in_run_in        = in_run_ff;
      streak_in        = streak_ff;
      count_in         = count_ff;
      unique case (state_ff)
         S_EVAL: begin
            chain_ctrl.write = store;
            in_run_in        = in_run_n;
            streak_in        = streak_n;
            count_in         = count_n;
         end
         S_RUN0: begin
            emit      = slot_free;
            emit_byte = ESC_BYTE;
         end
         S_RUN1: begin
            emit      = slot_free;
            emit_byte = level_ff;
         end
         S_RUN2: begin
            emit      = slot_free;
            emit_byte = run_val_ff;
         end
         S_FLUSH: begin
            emit             = slot_free;
            emit_byte        = head_data;
            chain_ctrl.shift = slot_free;
            if (slot_free) count_in = count_ff - CNT_W'(1);
         end
         S_ESC0, S_ESC1: begin
            emit      = slot_free;
            emit_byte = ESC_BYTE;
         end
         S_ESC2: begin
            emit      = slot_free;
            emit_byte = ESC_TAIL;
         end
         S_LIT: begin
            emit      = slot_free;
            emit_byte = sample_ff;
         end
         default: ;
      endcase
      burst_last = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_run_ff    <= 1'b0;
         streak_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_run_ff <= in_run_in;
         streak_ff <= streak_in;
         count_ff  <= count_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= req_tdata;
         last_ff   <= req_tlast;
      end
      if (state_ff == S_EVAL) begin
         run_val_ff  <= run_val_in;
         do_flush_ff <= do_flush_in;
         mid_ff      <= mid_in;
      end
      if (emit) begin
         rsp_byte_ff  <= emit_byte;
         rsp_burst_ff <= burst_last;
         rsp_end_ff   <= burst_last && last_ff;
      end
   end

   sre_pend_chain #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .wr_index  (count_ff),
      .wr_data   (sample_ff),
      .head_data (head_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_burst_ff;
   assign rsp_tlast  = rsp_end_ff;

endmodule
